@@ rtl/core/utf16_and_single_byte_to_utf8_assert.svh @@
// Assertion macros for the UTF-16 / single-byte to UTF-8 transcoder.
// Used by the top level only; expects clk and rst_n in the including scope.
`ifndef UTF16_AND_SINGLE_BYTE_TO_UTF8_ASSERT_SVH
`define UTF16_AND_SINGLE_BYTE_TO_UTF8_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define UTU8_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utu8 implication check failed");
// Next-cycle implication
`define UTU8_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utu8 next-cycle check failed");
`else
`define UTU8_ASSERT_IMPLY(label, ante, cons)
`define UTU8_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/utu8_pkg.sv @@
// Shared types, constants, code tables and UTF-8 helpers for the transcoder.
// No dependencies; imported by every module of the block.
package utu8_pkg;

    // Encoding modes
    localparam logic [1:0] MODE_UTF16LE = 2'd0;
    localparam logic [1:0] MODE_UTF16BE = 2'd1;
    localparam logic [1:0] MODE_CP1252  = 2'd2;
    localparam logic [1:0] MODE_LATIN2  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_ENCODING = 2'd0;
    localparam logic [1:0] REG_FATAL    = 2'd1;
    localparam logic [1:0] REG_KEEP_BOM = 2'd2;

    localparam int CP_W     = 21;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCOUNT_W = 2;

    localparam logic [15:0]     BOM_UNIT    = 16'hFEFF;
    localparam logic [CP_W-1:0] REPL_CP     = 21'h00FFFD;
    localparam logic [CP_W-1:0] SUPP_BASE   = 21'h010000;
    localparam logic [5:0]      HIGH_PREFIX = 6'b110110;
    localparam logic [5:0]      LOW_PREFIX  = 6'b110111;
    localparam logic [7:0]      LATIN2_BASE = 8'hA0;

    localparam logic [15:0] CP1252_HI [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    localparam logic [15:0] LATIN2_HI [96] = '{
        16'h00A0, 16'h0104, 16'h02D8, 16'h0141, 16'h00A4, 16'h013D, 16'h015A, 16'h00A7,
        16'h00A8, 16'h0160, 16'h015E, 16'h0164, 16'h0179, 16'h00AD, 16'h017D, 16'h017B,
        16'h00B0, 16'h0105, 16'h02DB, 16'h0142, 16'h00B4, 16'h013E, 16'h015B, 16'h02C7,
        16'h00B8, 16'h0161, 16'h015F, 16'h0165, 16'h017A, 16'h02DD, 16'h017E, 16'h017C,
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    // Configuration as seen by the front end
    typedef struct packed {
        logic [1:0] encoding;
        logic       fatal;
        logic       keep_bom;
    } utu8_cfg_t;

    // Work for one item: optional replacement, optional code point,
    // optional trailing replacement, optional error beat, in that order
    typedef struct packed {
        logic            pre;
        logic            cpv;
        logic [CP_W-1:0] cp;
        logic            post;
        logic            err;
    } utu8_cmd_t;

    // Number of UTF-8 bytes minus one
    function automatic logic [1:0] utf8_len_m1(input logic [CP_W-1:0] cp);
        logic [1:0] n;
        if (cp < 21'h000080) begin
            n = 2'd0;
        end else if (cp < 21'h000800) begin
            n = 2'd1;
        end else if (cp < 21'h010000) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Byte number idx of the UTF-8 form of cp
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (utf8_len_m1(cp))
            2'd0: b = {1'b0, cp[6:0]};
            2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2:
            begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/utf16_and_single_byte_to_utf8.sv @@
// Transcoder from UTF-16 LE/BE, Windows-1252 or ISO-8859-2 bytes to UTF-8
// beats. The front end takes one input beat per cycle while its two-entry
// command queue has room; the back end sends one output beat per cycle while
// out_ready is high, and an item produces 0 to 6 beats (mostly 1 to 3), so
// the sustained rate is set by the output serializer. The first output beat
// of an input beat passes through the queue, the serializer's command
// register and the output register. Configuration is written through
// cfg_write_en/cfg_index/cfg_data (0 encoding, 1 fatal, 2 keep BOM) while the
// block is idle.
module utf16_and_single_byte_to_utf8
    import utu8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       has_byte,
    input  logic       last_of_call,
    input  logic       stream_call,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_error,
    output logic       last
);

`include "utf16_and_single_byte_to_utf8_assert.svh"

    utu8_cfg_t cfg_reg;
    utu8_cmd_t cmd;
    utu8_cmd_t q_data;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_not_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                REG_ENCODING: cfg_reg.encoding <= cfg_data;
                REG_FATAL:    cfg_reg.fatal    <= cfg_data[0];
                REG_KEEP_BOM: cfg_reg.keep_bom <= cfg_data[0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    utu8_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .has_byte     (has_byte),
        .last_of_call (last_of_call),
        .stream_call  (stream_call),
        .q_full       (q_full),
        .push         (q_push),
        .cmd          (cmd)
    );

    utu8_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    utu8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_error    (is_error),
        .last        (last)
    );

    // An error beat is always the zero byte that closes its item
    `UTU8_ASSERT_IMPLY(a_err_beat_last, out_valid && is_error, last && out_byte == 8'h00)
    // The front end stalls while the queue is full
    `UTU8_ASSERT_IMPLY(a_no_accept_full, q_full, !in_ready)
    // Only commands with work enter the queue
    `UTU8_ASSERT_IMPLY(a_push_has_work, q_push, cmd.pre || cmd.cpv || cmd.post || cmd.err)
    // A pop with no push leaves room in the queue
    `UTU8_ASSERT_NEXT(a_pop_nonempty, q_pop && !q_push, !q_full)

endmodule

@@ rtl/core/utu8_queue.sv @@
// Two-entry command queue between the front end and the byte serializer.
// Depends on utu8_pkg for the command type and depth constants.
module utu8_queue
    import utu8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  utu8_cmd_t push_data,
    input  logic      pop,
    output utu8_cmd_t pop_data,
    output logic      not_empty,
    output logic      full
);

    utu8_cmd_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCOUNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/utu8_front.sv @@
// Front end: accepts input beats, pairs UTF-16 bytes, tracks surrogates,
// BOM and error dropping, and issues code point commands. Uses utu8_pkg.
module utu8_front
    import utu8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  utu8_cfg_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       has_byte,
    input  logic       last_of_call,
    input  logic       stream_call,
    input  logic       q_full,
    output logic       push,
    output utu8_cmd_t  cmd
);

    logic        bom_checked_reg, bom_checked_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_byte_valid_reg, held_byte_valid_next;
    logic [15:0] held_high_reg, held_high_next;
    logic        held_high_valid_reg, held_high_valid_next;
    logic        dropping_reg, dropping_next;
    logic        accept;
    logic        single;
    logic        err;
    logic        skip;
    logic        is_low;
    logic        is_high;
    logic [15:0] unit;
    logic [6:0]  latin2_idx;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign single     = cfg.encoding[1];
    assign latin2_idx = 7'(in_byte - LATIN2_BASE);
    assign unit       = (cfg.encoding == MODE_UTF16BE) ? {held_byte_reg, in_byte}
                                                       : {in_byte, held_byte_reg};
    assign is_low     = (unit[15:10] == LOW_PREFIX);
    assign is_high    = (unit[15:10] == HIGH_PREFIX);
    assign push       = accept && (cmd.pre || cmd.cpv || cmd.post || cmd.err);

    // Classify the beat and work out the next state
    always_comb
    begin
        bom_checked_next     = bom_checked_reg;
        held_byte_next       = held_byte_reg;
        held_byte_valid_next = held_byte_valid_reg;
        held_high_next       = held_high_reg;
        held_high_valid_next = held_high_valid_reg;
        dropping_next        = dropping_reg;
        cmd                  = '0;
        err                  = 1'b0;
        skip                 = 1'b0;

        // Single-byte modes carry nothing between beats
        if (single) begin
            held_byte_valid_next = 1'b0;
            held_byte_next       = '0;
            held_high_valid_next = 1'b0;
            held_high_next       = '0;
            bom_checked_next     = 1'b0;
        end

        if (has_byte && !dropping_reg) begin
            if (single) begin
                cmd.cpv = 1'b1;
                cmd.cp  = CP_W'(in_byte);
                if (cfg.encoding == MODE_CP1252) begin
                    if (in_byte[7:5] == 3'b100) begin
                        cmd.cp = CP_W'(CP1252_HI[in_byte[4:0]]);
                    end
                end else if (in_byte >= LATIN2_BASE) begin
                    cmd.cp = CP_W'(LATIN2_HI[latin2_idx]);
                end
            end else if (!held_byte_valid_reg) begin
                held_byte_next       = in_byte;
                held_byte_valid_next = 1'b1;
            end else begin
                held_byte_valid_next = 1'b0;
                held_byte_next       = '0;
                // Drop a leading byte-order mark unless keep_bom is set
                if (!bom_checked_reg) begin
                    bom_checked_next = 1'b1;
                    if (unit == BOM_UNIT && !cfg.keep_bom) begin
                        skip = 1'b1;
                    end
                end
                // Resolve a pending high surrogate
                if (!skip && held_high_valid_reg) begin
                    held_high_valid_next = 1'b0;
                    if (is_low) begin
                        cmd.cpv = 1'b1;
                        cmd.cp  = {1'b0, held_high_reg[9:0], unit[9:0]} + SUPP_BASE;
                        skip    = 1'b1;
                    end else if (cfg.fatal) begin
                        err  = 1'b1;
                        skip = 1'b1;
                    end else begin
                        cmd.pre = 1'b1;
                    end
                end
                if (!skip) begin
                    if (is_high) begin
                        held_high_next       = unit;
                        held_high_valid_next = 1'b1;
                    end else if (is_low) begin
                        if (cfg.fatal) begin
                            err = 1'b1;
                        end else begin
                            cmd.cpv = 1'b1;
                            cmd.cp  = REPL_CP;
                        end
                    end else begin
                        cmd.cpv = 1'b1;
                        cmd.cp  = CP_W'(unit);
                    end
                end
            end
        end

        // Close the call, or start dropping after a failure
        if (last_of_call) begin
            if (!err && !dropping_reg && !stream_call &&
                (held_byte_valid_next || held_high_valid_next)) begin
                if (cfg.fatal) begin
                    err = 1'b1;
                end else begin
                    cmd.post = 1'b1;
                end
            end
            if (!stream_call || err) begin
                held_byte_valid_next = 1'b0;
                held_byte_next       = '0;
                held_high_valid_next = 1'b0;
                held_high_next       = '0;
            end
            if (!stream_call) begin
                bom_checked_next = 1'b0;
            end
            dropping_next = 1'b0;
        end else if (err) begin
            dropping_next        = 1'b1;
            held_byte_valid_next = 1'b0;
            held_byte_next       = '0;
            held_high_valid_next = 1'b0;
            held_high_next       = '0;
        end
        cmd.err = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bom_checked_reg     <= 1'b0;
            held_byte_reg       <= '0;
            held_byte_valid_reg <= 1'b0;
            held_high_reg       <= '0;
            held_high_valid_reg <= 1'b0;
            dropping_reg        <= 1'b0;
        end else if (accept) begin
            bom_checked_reg     <= bom_checked_next;
            held_byte_reg       <= held_byte_next;
            held_byte_valid_reg <= held_byte_valid_next;
            held_high_reg       <= held_high_next;
            held_high_valid_reg <= held_high_valid_next;
            dropping_reg        <= dropping_next;
        end
    end

endmodule

@@ rtl/core/utu8_back.sv @@
// Back end: takes commands from the queue and serializes them into UTF-8
// beats through an output register. Uses utu8_pkg helpers.
module utu8_back
    import utu8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  utu8_cmd_t  q_data,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_error,
    output logic       last
);

    utu8_cmd_t       cmd_reg, cmd_next;
    logic            active_reg, active_next;
    logic [1:0]      idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            is_error_reg, is_error_next;
    logic            last_reg, last_next;
    logic [CP_W-1:0] cur_cp;
    logic            err_slot;
    logic            slot_done;
    logic            finishing;
    logic            emit;
    utu8_cmd_t       rest;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_error  = is_error_reg;
    assign last      = last_reg;

    // Pick the current slot and what remains after it
    always_comb
    begin
        err_slot = !cmd_reg.pre && !cmd_reg.cpv && !cmd_reg.post;
        cur_cp   = (!cmd_reg.pre && cmd_reg.cpv) ? cmd_reg.cp : REPL_CP;
        slot_done = err_slot || (idx_reg == utf8_len_m1(cur_cp));
        rest = cmd_reg;
        if (slot_done) begin
            if (cmd_reg.pre) begin
                rest.pre = 1'b0;
            end else if (cmd_reg.cpv) begin
                rest.cpv = 1'b0;
            end else if (cmd_reg.post) begin
                rest.post = 1'b0;
            end else begin
                rest.err = 1'b0;
            end
        end
        finishing = slot_done && !(rest.pre || rest.cpv || rest.post || rest.err);
        emit      = active_reg && (!out_valid_reg || out_ready);
        pop       = q_not_empty && (!active_reg || (emit && finishing));
    end

    // Advance the serializer and load the output register
    always_comb
    begin
        cmd_next       = cmd_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        is_error_next  = is_error_reg;
        last_next      = last_reg;

        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = err_slot ? 8'h00 : utf8_byte(cur_cp, idx_reg);
            is_error_next  = err_slot;
            last_next      = finishing;
            cmd_next       = rest;
            idx_next       = slot_done ? 2'd0 : idx_reg + 2'd1;
            if (finishing) begin
                active_next = 1'b0;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (pop) begin
            cmd_next    = q_data;
            active_next = 1'b1;
            idx_next    = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_reg       <= '0;
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cmd_reg       <= cmd_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold beat payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        is_error_reg <= is_error_next;
        last_reg     <= last_next;
    end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for utf16_and_single_byte_to_utf8.
// Holds its own transcoder prediction in a scoreboard class and drives the block
// through plain tasks; depends only on the RTL and utu8_pkg.
`timescale 1ns / 100ps

module tb_top;
    import utu8_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SEGMENT_ITEMS  = 22;

    localparam logic [15:0] UNIT_BOM       = 16'hFEFF;
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

    // Upper halves of the single-byte code pages
    localparam logic [15:0] WIN1252_UPPER [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    localparam logic [15:0] LATIN2_UPPER [96] = '{
        16'h00A0, 16'h0104, 16'h02D8, 16'h0141, 16'h00A4, 16'h013D, 16'h015A, 16'h00A7,
        16'h00A8, 16'h0160, 16'h015E, 16'h0164, 16'h0179, 16'h00AD, 16'h017D, 16'h017B,
        16'h00B0, 16'h0105, 16'h02DB, 16'h0142, 16'h00B4, 16'h013E, 16'h015B, 16'h02C7,
        16'h00B8, 16'h0161, 16'h015F, 16'h0165, 16'h017A, 16'h02DD, 16'h017E, 16'h017C,
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       lst;
    } utf8_beat_t;

    // Transcoder prediction and the queue of UTF-8 beats still owed by the block
    class utf8_scoreboard_t;
        logic [1:0]  mode;
        logic        fatal;
        logic        keep_bom;
        logic        bom_done;
        logic        byte_held;
        logic        high_held;
        logic        dropping;
        logic [7:0]  held_byte;
        logic [15:0] held_high;
        utf8_beat_t  step_q[$];
        utf8_beat_t  expected_q[$];
        int          errors;

        function new();
            mode = MODE_UTF16LE;
            fatal = 1'b0;
            keep_bom = 1'b0;
            bom_done = 1'b0;
            dropping = 1'b0;
            errors = 0;
            clear_held();
        endfunction

        function void clear_held();
            byte_held = 1'b0;
            high_held = 1'b0;
            held_byte = 8'h00;
            held_high = 16'h0000;
        endfunction

        function void write_reg(logic [1:0] idx, logic [1:0] value);
            case (idx)
                REG_ENCODING: mode = value;
                REG_FATAL:    fatal = value[0];
                REG_KEEP_BOM: keep_bom = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Append one beat of this item, capped at six
        function void emit(logic [7:0] data, logic err);
            utf8_beat_t t;
            if (step_q.size() >= 6)
                return;
            t.data = data;
            t.err = err;
            t.lst = 1'b0;
            step_q.push_back(t);
        endfunction

        function void emit_cp(logic [20:0] cp);
            if (cp < 21'h000080) begin
                emit({1'b0, cp[6:0]}, 1'b0);
            end else if (cp < 21'h000800) begin
                emit({3'b110, cp[10:6]}, 1'b0);
                emit({2'b10, cp[5:0]}, 1'b0);
            end else if (cp < 21'h010000) begin
                emit({4'b1110, cp[15:12]}, 1'b0);
                emit({2'b10, cp[11:6]}, 1'b0);
                emit({2'b10, cp[5:0]}, 1'b0);
            end else begin
                emit({5'b11110, cp[20:18]}, 1'b0);
                emit({2'b10, cp[17:12]}, 1'b0);
                emit({2'b10, cp[11:6]}, 1'b0);
                emit({2'b10, cp[5:0]}, 1'b0);
            end
        endfunction

        // Emit U+FFFD, or return 1 when the call must fail instead
        function logic replace_or_fail();
            if (fatal)
                return 1'b1;
            emit_cp(CP_REPLACEMENT);
            return 1'b0;
        endfunction

        // Consume one complete UTF-16 code unit; return 1 on fatal failure
        function logic decode_unit(logic [15:0] u);
            logic lo;
            logic hi;
            lo = (u >= 16'hDC00) && (u <= 16'hDFFF);
            hi = (u >= 16'hD800) && (u <= 16'hDBFF);
            if (!bom_done) begin
                bom_done = 1'b1;
                if (u == UNIT_BOM && !keep_bom)
                    return 1'b0;
            end
            if (high_held) begin
                high_held = 1'b0;
                if (lo) begin
                    emit_cp(21'h010000 + {1'b0, held_high[9:0], u[9:0]});
                    return 1'b0;
                end
                if (replace_or_fail())
                    return 1'b1;
            end
            if (hi) begin
                held_high = u;
                high_held = 1'b1;
                return 1'b0;
            end
            if (lo)
                return replace_or_fail();
            emit_cp({5'd0, u});
            return 1'b0;
        endfunction

        // Predict the beats caused by one accepted input beat
        function void note_input(logic [7:0] b, logic has, logic endc, logic strm);
            logic        single;
            logic        err;
            logic [15:0] u;
            logic [20:0] cp;
            utf8_beat_t  t;
            single = (mode == MODE_CP1252) || (mode == MODE_LATIN2);
            err = 1'b0;
            step_q.delete();
            if (single) begin
                clear_held();
                bom_done = 1'b0;
            end
            if (has && !dropping) begin
                if (single) begin
                    cp = {13'd0, b};
                    if (mode == MODE_CP1252) begin
                        if (b >= 8'h80 && b < 8'hA0)
                            cp = {5'd0, WIN1252_UPPER[b[4:0]]};
                    end else if (b >= 8'hA0) begin
                        cp = {5'd0, LATIN2_UPPER[int'(b) - 160]};
                    end
                    emit_cp(cp);
                end else if (!byte_held) begin
                    held_byte = b;
                    byte_held = 1'b1;
                end else begin
                    u = (mode == MODE_UTF16BE) ? {held_byte, b} : {b, held_byte};
                    byte_held = 1'b0;
                    held_byte = 8'h00;
                    err = decode_unit(u);
                end
            end
            // Close the call, or start dropping after a failure
            if (endc) begin
                if (!err && !dropping && !strm && (byte_held || high_held))
                    err = replace_or_fail();
                if (!strm || err)
                    clear_held();
                if (!strm)
                    bom_done = 1'b0;
                dropping = 1'b0;
            end else if (err) begin
                dropping = 1'b1;
                clear_held();
            end
            if (err) begin
                while (step_q.size() >= 6)
                    void'(step_q.pop_back());
                emit(8'h00, 1'b1);
            end
            if (step_q.size() > 0) begin
                t = step_q.pop_back();
                t.lst = 1'b1;
                step_q.push_back(t);
            end
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        endfunction

        function void check_result(logic [7:0] data, logic err, logic lst);
            utf8_beat_t t;
            if (expected_q.size() == 0) begin
                $error("unexpected beat: out_byte=%h is_error=%b last=%b", data, err, lst);
                errors++;
                return;
            end
            t = expected_q.pop_front();
            if (data !== t.data) begin
                $error("out_byte: expected %h, actual %h", t.data, data);
                errors++;
            end
            if (err !== t.err) begin
                $error("is_error: expected %b, actual %b", t.err, err);
                errors++;
            end
            if (lst !== t.lst) begin
                $error("last: expected %b, actual %b", t.lst, lst);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       last_of_call;
    logic       stream_call;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       is_error;
    logic       last;

    utf8_scoreboard_t sb;
    logic [1:0]       cur_mode;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               items_sent;
    int               quiet_cycles;

    utf16_and_single_byte_to_utf8 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .has_byte     (has_byte),
        .last_of_call (last_of_call),
        .stream_call  (stream_call),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_error     (is_error),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Stall the output side at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every output beat taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_byte, is_error, last);
    end

    // End the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one input beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_item(input logic [7:0] b, input logic has, input logic endc,
                             input logic strm);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        has_byte     <= has;
        last_of_call <= endc;
        stream_call  <= strm;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(b, has, endc, strm);
        if (has || endc)
            items_sent++;
    endtask

    // Send one code unit in the byte order of the current mode
    task automatic send_unit(input logic [15:0] u, input logic endc, input logic strm);
        if (cur_mode == MODE_UTF16BE) begin
            send_item(u[15:8], 1'b1, 1'b0, strm);
            send_item(u[7:0], 1'b1, endc, strm);
        end else begin
            send_item(u[7:0], 1'b1, 1'b0, strm);
            send_item(u[15:8], 1'b1, endc, strm);
        end
    endtask

    // Drop valid and wait until the block has drained
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic apply_config(input logic [1:0] enc, input logic fat, input logic keep);
        settle();
        write_reg(REG_ENCODING, enc);
        write_reg(REG_FATAL, {1'b0, fat});
        write_reg(REG_KEEP_BOM, {1'b0, keep});
        cur_mode = enc;
    endtask

    task automatic set_idle(input int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    // One UTF-16 decode call: mostly valid text, with surrogate faults and odd ends
    task automatic send_utf16_call();
        int          n;
        int          k;
        int          kind;
        int          tail;
        logic        strm;
        logic        close;
        logic [15:0] u;
        n = $urandom_range(4, 1);
        tail = $urandom_range(2);
        strm = ($urandom_range(99) < 25);
        if ($urandom_range(99) < 20)
            send_unit(UNIT_BOM, 1'b0, strm);
        for (k = 0; k < n; k++) begin
            close = (k == n - 1) && (tail == 0);
            kind = $urandom_range(99);
            if ($urandom_range(99) < 5)
                send_item(8'($urandom), 1'b0, 1'b0, strm);
            if (kind < 20) begin
                send_unit(16'hD800 | 16'($urandom_range(16'h3FF)), 1'b0, strm);
                send_unit(16'hDC00 | 16'($urandom_range(16'h3FF)), close, strm);
            end else begin
                if (kind < 28)
                    u = 16'hD800 | 16'($urandom_range(16'h3FF));
                else if (kind < 36)
                    u = 16'hDC00 | 16'($urandom_range(16'h3FF));
                else if (kind < 42)
                    u = 16'($urandom);
                else if (kind < 60)
                    u = 16'($urandom_range(16'h7F));
                else if (kind < 75)
                    u = 16'($urandom_range(16'h7FF, 16'h80));
                else if (kind < 90)
                    u = 16'($urandom_range(16'hD7FF, 16'h800));
                else
                    u = 16'($urandom_range(16'hFFFF, 16'hE000));
                send_unit(u, close, strm);
            end
        end
        // Unless the last unit closed it, close with a trailing odd byte or an empty item
        if (tail == 1)
            send_item(8'($urandom), 1'b1, 1'b1, strm);
        else if (tail == 2)
            send_item(8'($urandom), 1'b0, 1'b1, strm);
    endtask

    // One single-byte decode call, weighted toward the mapped upper half
    task automatic send_byte_call();
        int         n;
        int         k;
        logic       strm;
        logic [7:0] b;
        n = $urandom_range(6, 1);
        strm = 1'($urandom_range(1));
        for (k = 0; k < n; k++) begin
            b = ($urandom_range(99) < 60) ? 8'($urandom_range(255, 128)) : 8'($urandom);
            send_item(b, 1'b1, k == n - 1, strm);
        end
    endtask

    initial
    begin
        int seg;
        int start;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_ENCODING;
        cfg_data     = 2'd0;
        in_valid     = 1'b0;
        in_byte      = 8'h00;
        has_byte     = 1'b0;
        last_of_call = 1'b0;
        stream_call  = 1'b0;
        cur_mode     = MODE_UTF16LE;
        items_sent   = 0;
        set_idle(0);
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // UTF-16LE: BOM drop, surrogate pair, lone surrogates, ignored empty item
        apply_config(MODE_UTF16LE, 1'b0, 1'b0);
        send_unit(UNIT_BOM, 1'b0, 1'b0);
        send_unit(16'hD83D, 1'b0, 1'b0);
        send_unit(16'hDE00, 1'b0, 1'b0);
        send_unit(16'hDC00, 1'b0, 1'b0);
        send_unit(16'hD83D, 1'b0, 1'b0);
        send_unit(16'h0041, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        // Held high surrogate and odd byte at call end give one replacement
        send_unit(16'hDBFF, 1'b0, 1'b0);
        send_item(8'h7A, 1'b1, 1'b1, 1'b0);

        // UTF-16BE, fatal, BOM kept: fail, drop to call end, then a streamed unit
        apply_config(MODE_UTF16BE, 1'b1, 1'b1);
        send_unit(UNIT_BOM, 1'b0, 1'b0);
        send_unit(16'hDC00, 1'b0, 1'b0);
        send_item(8'h12, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1, 1'b1);
        send_item(8'h24, 1'b1, 1'b1, 1'b0);

        // Single-byte tables at their edges
        apply_config(MODE_CP1252, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 1'b0);
        send_item(8'h9F, 1'b1, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        apply_config(MODE_LATIN2, 1'b0, 1'b0);
        send_item(8'hA0, 1'b1, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);

        // Random calls across all modes and flag settings, idling varied per segment
        for (seg = 0; seg < 8; seg++) begin
            apply_config(seg[1:0], seg[0] ^ seg[2], seg[0]);
            set_idle((seg + seg / 4) % 4);
            start = items_sent;
            while (items_sent - start < SEGMENT_ITEMS) begin
                if ($urandom_range(99) < 10)
                    send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                else if (cur_mode == MODE_CP1252 || cur_mode == MODE_LATIN2)
                    send_byte_call();
                else
                    send_utf16_call();
            end
        end

        settle();
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
